@@ src/box_blur_3x3_rgb_unit_defines.svh @@
`ifndef BOX_BLUR_3X3_RGB_UNIT_DEFINES_SVH
`define BOX_BLUR_3X3_RGB_UNIT_DEFINES_SVH

// Same-cycle implication, off during reset.
`define BB_ASSERT_SAME(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off during reset.
`define BB_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/bblur_pkg.sv @@
package bblur_pkg;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  // Per-request control from the front to the back.
  typedef struct packed {
    logic wr;         // pixel: update line stores
    logic emit;       // request produces a result
    logic top_ok;     // row above the output pixel is inside the frame
    logic bot_ok;
    logic left_ok;
    logic right_ok;
    logic frame_end;
  } flags_t;

  // APB register index, taken from paddr[2]
  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_index_t;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  localparam int PIX_W       = $bits(pixel_t);
  localparam int FLAGS_W     = $bits(flags_t);
  localparam int QUEUE_DEPTH = 4;

endpackage

@@ src/bblur_ram.sv @@
module bblur_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                            clk,
  input  logic                            we,
  input  logic [$clog2(DEPTH)-1:0]        waddr,
  input  logic [WIDTH-1:0]                wdata,
  input  logic                            re,
  input  logic [$clog2(DEPTH)-1:0]        raddr,
  output logic [WIDTH-1:0]                rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/bblur_fifo.sv @@
module bblur_fifo #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             space,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             avail
);

  localparam int PW   = $clog2(DEPTH);
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CNTW-1:0]  count;
  logic             do_push;
  logic             do_pop;

  assign space    = count != CNTW'(DEPTH);
  assign avail    = count != '0;
  assign pop_data = mem[rd_ptr];
  assign do_push  = push && space;
  assign do_pop   = pop && avail;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + CNTW'(1);
        2'b01:   count <= count - CNTW'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

@@ src/bblur_front.sv @@
`include "box_blur_3x3_rgb_unit_defines.svh"

module bblur_front #(
  parameter int CW = 10
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [CW-1:0]         wm1,        // frame width - 1, clamped
  input  logic [15:0]           hm1,        // frame height - 1, clamped
  input  logic                  restart,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [23:0]           s_tdata,    // red_in, green_in, blue_in
  input  logic                  s_tuser,    // cmd
  input  logic                  space,
  output logic                  push,
  output logic [CW-1:0]         q_addr,
  output bblur_pkg::pixel_t     q_px,
  output bblur_pkg::flags_t     q_flags
);

  logic          take;
  logic          px_emit;
  logic          in_done;     // all pixels of the frame are in
  logic [CW-1:0] in_col;
  logic [15:0]   in_row;
  logic [CW-1:0] out_col;
  logic [15:0]   out_row;
  logic          out_last_col;
  logic          out_last_row;

  assign s_tready = space;
  assign take     = s_tvalid && s_tready;

  always_comb begin
    out_last_col = out_col == wm1;
    out_last_row = out_row == hm1;
    // results start once the pixel below-right of the first one arrives
    px_emit = (in_row != 16'd0) && !((in_row == 16'd1) && (in_col == '0));
    // during the frame a drain is dropped; after it every request drains
    push = take && (in_done || (s_tuser != bblur_pkg::CMD_DRAIN));

    q_flags.wr        = !in_done;
    q_flags.emit      = in_done || px_emit;
    q_flags.top_ok    = out_row != 16'd0;
    q_flags.bot_ok    = !out_last_row;
    q_flags.left_ok   = out_col != '0;
    q_flags.right_ok  = !out_last_col;
    q_flags.frame_end = out_last_row && out_last_col;

    if (in_done) begin
      q_addr = out_last_col ? '0 : out_col + CW'(1);
      q_px   = '0;
    end else begin
      q_addr       = in_col;
      q_px.red     = s_tdata[7:0];
      q_px.green   = s_tdata[15:8];
      q_px.blue    = s_tdata[23:16];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      in_done <= 1'b0;
      in_col  <= '0;
      in_row  <= '0;
      out_col <= '0;
      out_row <= '0;
    end else if (push) begin
      if (!in_done) begin
        if (in_col == wm1) begin
          in_col <= '0;
          if (in_row == hm1) begin
            in_done <= 1'b1;
          end else begin
            in_row <= in_row + 16'd1;
          end
        end else begin
          in_col <= in_col + CW'(1);
        end
      end
      if (q_flags.emit) begin
        if (q_flags.frame_end) begin
          in_done <= 1'b0;
          in_col  <= '0;
          in_row  <= '0;
          out_col <= '0;
          out_row <= '0;
        end else if (out_last_col) begin
          out_col <= '0;
          out_row <= out_row + 16'd1;
        end else begin
          out_col <= out_col + CW'(1);
        end
      end
    end
  end

  `BB_ASSERT_NEXT(a_frame_wrap, clk, rst, push && q_flags.emit && q_flags.frame_end, !in_done && (in_row == 16'd0) && (in_col == '0), "frame end did not restart counters")
  `BB_ASSERT_SAME(a_done_col, clk, rst, in_done, in_col == '0, "column not wrapped after last pixel")
  `BB_ASSERT_SAME(a_drain_phase, clk, rst, push && !q_flags.wr, in_done, "drain request queued during frame")

endmodule

@@ src/bblur_back.sv @@
`include "box_blur_3x3_rgb_unit_defines.svh"

module bblur_back #(
  parameter int CW    = 10,
  parameter int DEPTH = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  logic [CW-1:0]      q_addr,
  input  bblur_pkg::pixel_t  q_px,
  input  bblur_pkg::flags_t  q_flags,
  output logic               q_pop,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [23:0]        m_tdata,    // red_out, green_out, blue_out
  output logic               m_tlast     // frame_end
);

  typedef struct packed {
    bblur_pkg::pixel_t top;
    bblur_pkg::pixel_t mid;
    bblur_pkg::pixel_t bot;
  } col_t;

  typedef enum logic [1:0] {NC4, NC6, NC9} ncode_t;

  function automatic logic [9:0] sum3(input logic [7:0] a, input logic [7:0] b,
                                      input logic [7:0] c, input logic use_a,
                                      input logic use_c);
    sum3 = (use_a ? 10'(a) : 10'd0) + 10'(b) + (use_c ? 10'(c) : 10'd0);
  endfunction

  // floor((2*s + n) / (2*n)) for n = 4, 6, 9: a shift for 4, reciprocal multiplies for 6 and 9
  function automatic logic [7:0] rmean(input logic [11:0] s, input ncode_t nc);
    logic [12:0] t4;
    logic [12:0] t6;
    logic [12:0] t9;
    logic [22:0] p6;
    logic [24:0] p9;
    t4 = 13'(s) + 13'd2;
    t6 = 13'(s) + 13'd3;
    t9 = 13'(s) + 13'd4;
    p6 = 23'(t6[12:1]) * 23'd683;
    p9 = 25'(t9) * 25'd1821;
    case (nc)
      NC4:     rmean = t4[9:2];
      NC6:     rmean = p6[18:11];
      NC9:     rmean = p9[21:14];
      default: rmean = '0;
    endcase
  endfunction

  logic adv;

  // stage B: line store data arrives
  logic                 valid_b;
  logic [CW-1:0]        addr_b;
  bblur_pkg::pixel_t    px_b;
  bblur_pkg::flags_t    flags_b;
  bblur_pkg::pixel_t    older_q;
  bblur_pkg::pixel_t    prev_q;
  logic                 ram_we;

  col_t                 win [3];
  col_t                 win_next [3];
  logic [9:0]           csum_next [3][3];

  // stage C: column sums
  logic                 valid_c;
  logic [9:0]           csum_c [3][3];
  logic                 left_c;
  logic                 right_c;
  logic                 bot_c;
  logic                 fe_c;
  ncode_t               ncode_c;
  ncode_t               ncode_next;

  // stage D: window sums
  logic                 valid_d;
  logic [11:0]          sum_d [3];
  logic [11:0]          sum_next [3];
  ncode_t               ncode_d;
  logic                 fe_d;

  assign adv    = !m_tvalid || m_tready;
  assign q_pop  = adv && q_valid;
  assign ram_we = adv && valid_b && flags_b.wr;

  bblur_ram #(.WIDTH(bblur_pkg::PIX_W), .DEPTH(DEPTH)) u_older (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr_b),
    .wdata (prev_q),
    .re    (q_pop),
    .raddr (q_addr),
    .rdata (older_q)
  );

  bblur_ram #(.WIDTH(bblur_pkg::PIX_W), .DEPTH(DEPTH)) u_prev (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr_b),
    .wdata (px_b),
    .re    (q_pop),
    .raddr (q_addr),
    .rdata (prev_q)
  );

  always_comb begin
    win_next[0]     = win[1];
    win_next[1]     = win[2];
    win_next[2].top = older_q;
    win_next[2].mid = prev_q;
    win_next[2].bot = px_b;
    for (int j = 0; j < 3; j++) begin
      csum_next[j][0] = sum3(win_next[j].top.red, win_next[j].mid.red,
                             win_next[j].bot.red, flags_b.top_ok, flags_b.bot_ok);
      csum_next[j][1] = sum3(win_next[j].top.green, win_next[j].mid.green,
                             win_next[j].bot.green, flags_b.top_ok, flags_b.bot_ok);
      csum_next[j][2] = sum3(win_next[j].top.blue, win_next[j].mid.blue,
                             win_next[j].bot.blue, flags_b.top_ok, flags_b.bot_ok);
    end
    if (flags_b.top_ok && flags_b.bot_ok && flags_b.left_ok && flags_b.right_ok) begin
      ncode_next = NC9;
    end else if ((flags_b.top_ok && flags_b.bot_ok) ||
                 (flags_b.left_ok && flags_b.right_ok)) begin
      ncode_next = NC6;
    end else begin
      ncode_next = NC4;
    end
    for (int ch = 0; ch < 3; ch++) begin
      sum_next[ch] = (left_c ? 12'(csum_c[0][ch]) : 12'd0) + 12'(csum_c[1][ch])
                   + (right_c ? 12'(csum_c[2][ch]) : 12'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_b  <= 1'b0;
      valid_c  <= 1'b0;
      valid_d  <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (adv) begin
      valid_b  <= q_valid;
      valid_c  <= valid_b && flags_b.emit;
      valid_d  <= valid_c;
      m_tvalid <= valid_d;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      addr_b  <= q_addr;
      px_b    <= q_px;
      flags_b <= q_flags;
      if (valid_b) begin
        win <= win_next;
      end
      csum_c  <= csum_next;
      left_c  <= flags_b.left_ok;
      right_c <= flags_b.right_ok;
      bot_c   <= flags_b.bot_ok;
      fe_c    <= flags_b.frame_end;
      ncode_c <= ncode_next;
      sum_d   <= sum_next;
      ncode_d <= ncode_c;
      fe_d    <= fe_c;
      m_tdata <= {rmean(sum_d[2], ncode_d), rmean(sum_d[1], ncode_d),
                  rmean(sum_d[0], ncode_d)};
      m_tlast <= fe_d;
    end
  end

  `BB_ASSERT_NEXT(a_result_out, clk, rst, valid_d && adv, m_tvalid, "finished sum lost before output")
  `BB_ASSERT_SAME(a_end_clip, clk, rst, valid_c && fe_c, !right_c && !bot_c, "frame end pixel not clipped at corner")
  `BB_ASSERT_SAME(a_corner_sum, clk, rst, valid_d && (ncode_d == NC4), sum_d[0] <= 12'd1020, "corner sum out of range")

endmodule

@@ src/box_blur_3x3_rgb_unit.sv @@
// Channel   Dir  Payload
// s_*       in   tdata = red_in, green_in, blue_in; tuser = cmd (1 drains)
// m_*       out  tdata = red_out, green_out, blue_out; tlast = frame_end
// APB       in   0x0 frame_width, 0x4 frame_height
//
// One request per clock sustained while the output is not stalled; m_tvalid rises
// after the request that completes its window passes the queue, registered line
// store read, column sum, window sum, then reciprocal divide into the output register.
// Synchronous reset clears control only; line stores start undefined, no clear pass.
// An output stall freezes the back pipeline; the 4-entry queue keeps taking
// requests until it fills.
module box_blur_3x3_rgb_unit #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [7:0] red_in, [15:8] green_in, [23:16] blue_in
  input  logic        s_tuser,   // cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [7:0] red_out, [15:8] green_out, [23:16] blue_out
  output logic        m_tlast,   // frame_end
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int QW = CW + bblur_pkg::PIX_W + bblur_pkg::FLAGS_W;

  logic [10:0]       frame_width;
  logic [15:0]       frame_height;
  logic              cfg_wr;
  logic [CW-1:0]     wm1;
  logic [15:0]       hm1;

  logic              space;
  logic              push;
  logic [CW-1:0]     f_addr;
  bblur_pkg::pixel_t f_px;
  bblur_pkg::flags_t f_flags;

  logic [QW-1:0]     q_data;
  logic              q_valid;
  logic              q_pop;
  logic [CW-1:0]     q_addr;
  bblur_pkg::pixel_t q_px;
  bblur_pkg::flags_t q_flags;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == bblur_pkg::REG_FRAME_HEIGHT) ? {16'd0, frame_height}
                                                            : {21'd0, frame_width};

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= 11'd640;
      frame_height <= 16'd480;
    end else if (cfg_wr) begin
      case (paddr[2])
        bblur_pkg::REG_FRAME_WIDTH:  frame_width  <= pwdata[10:0];
        bblur_pkg::REG_FRAME_HEIGHT: frame_height <= pwdata[15:0];
        default:                     frame_width  <= frame_width;
      endcase
    end
  end

  // out-of-range sizes are clamped
  always_comb begin
    if (frame_width < 11'd2) begin
      wm1 = CW'(1);
    end else if (int'(frame_width) > MAX_WIDTH) begin
      wm1 = CW'(MAX_WIDTH - 1);
    end else begin
      wm1 = CW'(frame_width - 11'd1);
    end
    hm1 = (frame_height < 16'd2) ? 16'd1 : frame_height - 16'd1;
  end

  bblur_front #(.CW(CW)) u_front (
    .clk      (clk),
    .rst      (rst),
    .wm1      (wm1),
    .hm1      (hm1),
    .restart  (cfg_wr),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .space    (space),
    .push     (push),
    .q_addr   (f_addr),
    .q_px     (f_px),
    .q_flags  (f_flags)
  );

  bblur_fifo #(.WIDTH(QW), .DEPTH(bblur_pkg::QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({f_addr, f_px, f_flags}),
    .space     (space),
    .pop       (q_pop),
    .pop_data  (q_data),
    .avail     (q_valid)
  );

  assign {q_addr, q_px, q_flags} = q_data;

  bblur_back #(.CW(CW), .DEPTH(MAX_WIDTH)) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_addr   (q_addr),
    .q_px     (q_px),
    .q_flags  (q_flags),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule
